>>> sv/gda_pkg.sv
// shared constants and helpers for the gregorian date arithmetic block
`default_nettype none
package gda_pkg;
  localparam int MAX_YEAR = 9999;
  localparam int CYCLE400 = 146097;
  localparam int CYCLE100 = 36524;
  localparam int CYCLE4   = 1461;
  // day numbers here stay below 2^25 for any 14-bit year
  localparam int SW = 26;

  // floor(v / 100): drop two bits, then multiply by the reciprocal of 25
  function automatic logic [16:0] div100(input logic [16:0] v);
    logic [29:0] prod;
    begin
      prod = 30'(v[16:2]) * 30'd5243;
      div100 = 17'(prod[29:17]);
    end
  endfunction

  function automatic logic [SW-1:0] days_before_year(input logic [16:0] y);
    logic [16:0] p;
    logic [16:0] c;
    begin
      p = y - 17'd1;
      c = div100(p);
      days_before_year = SW'(p * 365) + SW'(p / 4) - SW'(c) + SW'(c >> 2);
    end
  endfunction

  localparam logic [SW-1:0] TOP = days_before_year(17'(MAX_YEAR + 1));

  // divisible by 400 is divisible by 100 and by 16
  function automatic logic is_leap(input logic [16:0] y);
    logic cent;
    begin
      cent = (div100(y) * 17'd100) == y;
      is_leap = (y[1:0] == 2'd0) && (!cent || (y[3:0] == 4'd0));
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2: month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  // days before month m within a year
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] t;
    begin
      case (m)
        4'd1: t = 9'd0;    4'd2: t = 9'd31;   4'd3: t = 9'd59;   4'd4: t = 9'd90;
        4'd5: t = 9'd120;  4'd6: t = 9'd151;  4'd7: t = 9'd181;  4'd8: t = 9'd212;
        4'd9: t = 9'd243;  4'd10: t = 9'd273; 4'd11: t = 9'd304; default: t = 9'd334;
      endcase
      days_before_month = t + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
    end
  endfunction
endpackage
`default_nettype wire

>>> sv/gregorian_date_arithmetic.sv
// top level: date shift, day number, distance and compare
//  channel   signals                              transfer
//  command   start, busy, base_*, day_offset,     start && !busy
//            other_*
//  result    done, shifted_*, day_number, ...     done high for one cycle
// an item holds busy through SER, PREP and the subtractions of the shared unit:
// up to 24 of 400 years, 3 of 100, 24 of 4, 3 of 1 and 11 months
// SER and PREP convert both dates to day numbers and clamp the shift
// done pulses in the first cycle with busy low, when the next start can be taken
// synchronous reset returns to idle; the result cannot be stalled
`default_nettype none
module gregorian_date_arithmetic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [13:0] base_year,
  input  wire logic [3:0]  base_month,
  input  wire logic [4:0]  base_day,
  input  wire logic signed [22:0] day_offset,
  input  wire logic [13:0] other_year,
  input  wire logic [3:0]  other_month,
  input  wire logic [4:0]  other_day,
  output logic done,
  output logic [13:0] shifted_year,
  output logic [3:0]  shifted_month,
  output logic [4:0]  shifted_day,
  output logic [21:0] day_number,
  output logic [21:0] day_distance,
  output logic is_before,
  output logic is_same,
  output logic range_error
);
  localparam int SW = gda_pkg::SW;
  typedef enum logic [2:0] {IDLE, SER, PREP, C400, C100, C4, C1, MON} state_t;
  state_t state;
  logic [13:0] a_year, b_year;
  logic [3:0]  a_month, b_month;
  logic [4:0]  a_day, b_day;
  logic signed [22:0] offset;
  logic [SW-1:0] sa, sb, na, nb, n;
  logic [16:0] yr;
  logic [3:0] mo;
  logic [2:0] cnt;
  logic [SW-1:0] sub_b, diff;
  logic ge, leap;
  logic signed [SW:0] t;

  gda_serial u_a (.year(a_year), .month(a_month), .day(a_day), .serial(sa));
  gda_serial u_b (.year(b_year), .month(b_month), .day(b_day), .serial(sb));

  function automatic logic [21:0] sat22(input logic [SW-1:0] v);
    sat22 = (v > SW'(22'h3FFFFF)) ? 22'h3FFFFF : v[21:0];
  endfunction

  assign leap = gda_pkg::is_leap(yr);
  // the shared subtract and compare unit
  always_comb begin
    case (state)
      C400: sub_b = SW'(gda_pkg::CYCLE400);
      C100: sub_b = SW'(gda_pkg::CYCLE100);
      C4:   sub_b = SW'(gda_pkg::CYCLE4);
      C1:   sub_b = SW'(365);
      MON:  sub_b = SW'(gda_pkg::month_len(mo, leap));
      default: sub_b = '0;
    endcase
    diff = n - sub_b;
    ge = n >= sub_b;
    t = $signed({1'b0, na}) + (SW+1)'(offset);
  end

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == MON) && !(ge && mo < 4'd12);
      case (state)
        IDLE: if (start) begin
          a_year <= base_year;
          a_month <= base_month;
          a_day <= base_day;
          offset <= day_offset;
          b_year <= other_year;
          b_month <= other_month;
          b_day <= other_day;
          state <= SER;
        end
        SER: begin
          na <= sa;
          nb <= sb;
          state <= PREP;
        end
        PREP: begin
          day_number <= sat22(na);
          day_distance <= sat22((na >= nb) ? na - nb : nb - na);
          is_before <= na < nb;
          is_same <= na == nb;
          yr <= 17'd1;
          mo <= 4'd1;
          cnt <= '0;
          if (t < 1) begin
            n <= '0; range_error <= 1'b1;
          end else if (t > $signed({1'b0, gda_pkg::TOP})) begin
            n <= gda_pkg::TOP - 1'b1; range_error <= 1'b1;
          end else begin
            n <= SW'(t - 1); range_error <= 1'b0;
          end
          state <= C400;
        end
        C400: if (ge) begin
          n <= diff; yr <= yr + 17'd400;
        end else begin
          state <= C100; cnt <= '0;
        end
        C100: if (ge && cnt < 3'd3) begin
          n <= diff; yr <= yr + 17'd100; cnt <= cnt + 3'd1;
        end else begin
          state <= C4; cnt <= '0;
        end
        C4: if (ge) begin
          n <= diff; yr <= yr + 17'd4;
        end else begin
          state <= C1;
        end
        C1: if (ge && cnt < 3'd3) begin
          n <= diff; yr <= yr + 17'd1; cnt <= cnt + 3'd1;
        end else begin
          state <= MON;
        end
        MON: if (ge && mo < 4'd12) begin
          n <= diff; mo <= mo + 4'd1;
        end else begin
          shifted_year <= yr[13:0];
          shifted_month <= mo;
          shifted_day <= n[4:0] + 5'd1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> state == IDLE) else $error("result outside idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item not worked");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_before && is_same)) else $error("before and same together");
endmodule
`default_nettype wire

>>> sv/gda_serial.sv
// date to day number conversion, one date at a time
`default_nettype none
module gda_serial (
  input  wire logic [13:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  output logic [gda_pkg::SW-1:0] serial
);
  logic [16:0] y;
  logic [3:0]  m;
  always_comb begin
    y = (year == 14'd0) ? 17'd1 : 17'(year);
    m = (month == 4'd0) ? 4'd1 : ((month > 4'd12) ? 4'd12 : month);
    serial = gda_pkg::days_before_year(y)
           + gda_pkg::SW'(gda_pkg::days_before_month(m, gda_pkg::is_leap(y)))
           + gda_pkg::SW'(day);
  end
endmodule
`default_nettype wire

>>> verif/gda_checker.sv
// checker for the gregorian date block: predicts each result and compares
`timescale 1ns / 1ps
module gda_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire logic [13:0] base_year,
  input  wire logic [3:0]  base_month,
  input  wire logic [4:0]  base_day,
  input  wire logic signed [22:0] day_offset,
  input  wire logic [13:0] other_year,
  input  wire logic [3:0]  other_month,
  input  wire logic [4:0]  other_day,
  input  wire logic done,
  input  wire logic [13:0] shifted_year,
  input  wire logic [3:0]  shifted_month,
  input  wire logic [4:0]  shifted_day,
  input  wire logic [21:0] day_number,
  input  wire logic [21:0] day_distance,
  input  wire logic is_before,
  input  wire logic is_same,
  input  wire logic range_error,
  output int errors,
  output int pending
);
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] number;
    logic [21:0] distance;
    logic earlier;
    logic same;
    logic err;
  } date_result_t;

  date_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint m, longint y);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint years_to_days(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint date_to_serial(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
    longint y, m, s;
    y = yr;
    m = mo;
    if (y < 1) y = 1;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    s = years_to_days(y);
    for (longint i = 1; i < m; i++) s += month_days(i, y);
    return s + dy;
  endfunction

  function automatic longint clip22(longint v);
    if (v < 0) return 0;
    if (v > 64'h3FFFFF) return 64'h3FFFFF;
    return v;
  endfunction

  function automatic date_result_t predict_dates(
      logic [13:0] by, logic [3:0] bm, logic [4:0] bd, logic signed [22:0] off,
      logic [13:0] oy, logic [3:0] om, logic [4:0] od);
    date_result_t r;
    longint a, b, t, n, q400, q100, q4, q1, y, mo, ml, top, span;
    a = date_to_serial(by, bm, bd);
    b = date_to_serial(oy, om, od);
    top = years_to_days(longint'(gda_pkg::MAX_YEAR) + 1);
    t = a + longint'(off);
    r.err = 1'b0;
    if (t < 1) begin
      t = 1;
      r.err = 1'b1;
    end else if (t > top) begin
      t = top;
      r.err = 1'b1;
    end
    n = t - 1;
    q400 = n / gda_pkg::CYCLE400;
    n = n % gda_pkg::CYCLE400;
    q100 = n / gda_pkg::CYCLE100;
    if (q100 > 3) q100 = 3;
    n -= q100 * gda_pkg::CYCLE100;
    q4 = n / gda_pkg::CYCLE4;
    n = n % gda_pkg::CYCLE4;
    q1 = n / 365;
    if (q1 > 3) q1 = 3;
    n -= q1 * 365;
    y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    mo = 1;
    forever begin
      ml = month_days(mo, y);
      if (n < ml || mo >= 12) break;
      n -= ml;
      mo++;
    end
    span = a - b;
    if (span < 0) span = -span;
    r.year = y[13:0];
    r.month = mo[3:0];
    r.day = 5'(n + 1);
    r.number = 22'(clip22(a));
    r.distance = 22'(clip22(span));
    r.earlier = a < b;
    r.same = a == b;
    return r;
  endfunction

  always @(posedge clk) begin
    date_result_t e;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy)
        expected_q.push_back(predict_dates(base_year, base_month, base_day, day_offset,
                                           other_year, other_month, other_day));
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (shifted_year !== e.year ||
              shifted_month !== e.month ||
              shifted_day !== e.day ||
              day_number !== e.number ||
              day_distance !== e.distance ||
              is_before !== e.earlier ||
              is_same !== e.same ||
              range_error !== e.err)
            errors <= errors + 1;
          if (shifted_year !== e.year)
            $error("shifted_year exp %0d got %0d", e.year, shifted_year);
          if (shifted_month !== e.month)
            $error("shifted_month exp %0d got %0d", e.month, shifted_month);
          if (shifted_day !== e.day)
            $error("shifted_day exp %0d got %0d", e.day, shifted_day);
          if (day_number !== e.number)
            $error("day_number exp %0d got %0d", e.number, day_number);
          if (day_distance !== e.distance)
            $error("day_distance exp %0d got %0d", e.distance, day_distance);
          if (is_before !== e.earlier)
            $error("is_before exp %0d got %0d", e.earlier, is_before);
          if (is_same !== e.same)
            $error("is_same exp %0d got %0d", e.same, is_same);
          if (range_error !== e.err)
            $error("range_error exp %0d got %0d", e.err, range_error);
        end
      end
    end
  end
endmodule

>>> verif/tb.sv
// testbench top: drives date commands into the block and gives the verdict
`timescale 1ns / 1ps
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [13:0] base_year = '0, other_year = '0;
  logic [3:0] base_month = '0, other_month = '0;
  logic [4:0] base_day = '0, other_day = '0;
  logic signed [22:0] day_offset = '0;
  logic busy, done, is_before, is_same, range_error;
  logic [13:0] shifted_year;
  logic [3:0] shifted_month;
  logic [4:0] shifted_day;
  logic [21:0] day_number, day_distance;
  int errors, pending;
  int idle_cycles = 0;

  localparam int WATCHDOG = 20000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gregorian_date_arithmetic dut (.*);
  gda_checker chk (.*);

  // cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
    repeat (n) @(posedge clk);
  endtask

  // one command transfer; start stays high when the next one follows at once
  task automatic send_dates(logic [13:0] by, logic [3:0] bm, logic [4:0] bd,
                            logic signed [22:0] off, logic [13:0] oy,
                            logic [3:0] om, logic [4:0] od, bit gaps);
    start <= 1'b1;
    base_year <= by; base_month <= bm; base_day <= bd; day_offset <= off;
    other_year <= oy; other_month <= om; other_day <= od;
    do @(posedge clk); while (busy);
    if (gaps && $urandom_range(0, 3) != 0) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  function automatic logic [13:0] rand_year();
    case ($urandom_range(0, 5))
      0: return 14'($urandom_range(0, 16383));
      1: return 14'($urandom_range(1, 3));
      2: return 14'($urandom_range(9990, 9999));
      3: return 14'(400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100);
      default: return 14'($urandom_range(1, 9999));
    endcase
  endfunction

  function automatic logic signed [22:0] rand_offset();
    case ($urandom_range(0, 4))
      0: return 23'($urandom);
      1: return 23'(int'($urandom_range(0, 800)) - 400);
      2: return 23'(int'($urandom_range(0, 200000)) - 100000);
      default: return 23'(int'($urandom_range(0, 7304118)) - 3652059);
    endcase
  endfunction

  initial begin
    logic [13:0] y;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, leap days, out-of-range fields and saturation
    send_dates(14'd1, 4'd1, 5'd1, 23'sd0, 14'd1, 4'd1, 5'd1, 0);
    send_dates(14'd9999, 4'd12, 5'd31, 23'sd0, 14'd1, 4'd1, 5'd1, 0);
    send_dates(14'd1, 4'd1, 5'd1, -23'sd1, 14'd9999, 4'd12, 5'd31, 0);
    send_dates(14'd9999, 4'd12, 5'd31, 23'sd1, 14'd9999, 4'd12, 5'd31, 0);
    send_dates(14'd1, 4'd1, 5'd1, 23'sd3652058, 14'd2, 4'd1, 5'd1, 0);
    send_dates(14'd9999, 4'd12, 5'd31, -23'sd3652058, 14'd5, 4'd5, 5'd5, 0);
    send_dates(14'd2000, 4'd2, 5'd28, 23'sd1, 14'd2000, 4'd2, 5'd29, 0);
    send_dates(14'd1900, 4'd2, 5'd28, 23'sd1, 14'd1900, 4'd3, 5'd1, 0);
    send_dates(14'd2004, 4'd3, 5'd1, -23'sd1, 14'd2004, 4'd2, 5'd29, 0);
    send_dates(14'd2023, 4'd12, 5'd31, 23'sd1, 14'd2024, 4'd1, 5'd1, 0);
    send_dates(14'd0, 4'd0, 5'd0, 23'sd0, 14'd0, 4'd0, 5'd0, 0);
    send_dates(14'd2021, 4'd15, 5'd31, 23'sd10, 14'd2021, 4'd13, 5'd1, 0);
    send_dates(14'd2021, 4'd2, 5'd31, 23'sd0, 14'd2021, 4'd3, 5'd3, 0);
    send_dates(14'd16383, 4'd15, 5'd31, 23'sh400000, 14'd1, 4'd1, 5'd1, 0);
    send_dates(14'd16383, 4'd6, 5'd15, 23'sd4194303, 14'd16383, 4'd6, 5'd15, 0);
    send_dates(14'd1600, 4'd12, 5'd31, 23'sd366, 14'd1601, 4'd1, 5'd1, 1);
    send_dates(14'd2400, 4'd2, 5'd29, -23'sd146097, 14'd1, 4'd1, 5'd1, 1);
    start <= 1'b0;
    // hold off until every result is back
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 1000; i++) begin
      y = rand_year();
      send_dates(y, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), rand_offset(),
                 ($urandom_range(0, 3) == 0) ? y : rand_year(),
                 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                 i < 100 || i >= 200);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule
